>>> src/telnet_option_negotiator_core_assert.svh
// Assertion macros used by the checker file of the telnet option negotiator.
`ifndef TELNET_OPTION_NEGOTIATOR_CORE_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TONC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("telnet negotiator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TONC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("telnet negotiator check failed");

`endif

>>> src/tonc_pkg.sv
// Shared types and protocol constants of the telnet option negotiator.
`default_nettype none

package tonc_pkg;

    localparam logic [7:0] TN_IAC  = 8'hFF;
    localparam logic [7:0] TN_WILL = 8'hFB;
    localparam logic [7:0] TN_WONT = 8'hFC;
    localparam logic [7:0] TN_DO   = 8'hFD;
    localparam logic [7:0] TN_DONT = 8'hFE;
    localparam logic [7:0] TN_SB   = 8'hFA;
    localparam logic [7:0] TN_SE   = 8'hF0;

    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] SUB_IS    = 8'd0;
    localparam logic [7:0] SUB_SEND  = 8'd1;

    localparam logic [15:0] COLS_RESET = 16'd80;
    localparam logic [15:0] ROWS_RESET = 16'd25;

    // Register indexes of the configuration port
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic DEST_DISPLAY = 1'b0;
    localparam logic DEST_NETWORK = 1'b1;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_IAC    = 3'd1,
        ST_CMD    = 3'd2,
        ST_SB     = 3'd3,
        ST_SB_IAC = 3'd4
    } parse_state_t;

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_CMD   = 2'd1,
        ACT_NAWS  = 2'd2,
        ACT_TTYPE = 2'd3
    } act_kind_t;

    // One classified item waiting to be expanded into output bytes
    typedef struct packed {
        act_kind_t  kind;
        logic [7:0] cmd;
        logic [7:0] data;
        logic       echo;
    } action_t;

endpackage

`default_nettype wire

>>> src/tonc_parser.sv
// Front end: IAC parser that classifies each received byte into an action.
`default_nettype none

module tonc_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    output tonc_pkg::action_t     act,
    output logic                  act_valid
);

    tonc_pkg::parse_state_t state_reg, state_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] subopt_reg, subopt_next;
    logic [1:0] subpos_reg, subpos_next;
    logic       echo_reg, echo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tonc_pkg::ST_NORMAL;
            held_reg   <= 8'd0;
            subopt_reg <= 8'd0;
            subpos_reg <= 2'd0;
            echo_reg   <= 1'b1;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            subopt_reg <= subopt_next;
            subpos_reg <= subpos_next;
            echo_reg   <= echo_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        subopt_next = subopt_reg;
        subpos_next = subpos_reg;
        echo_next   = echo_reg;
        act_valid   = 1'b0;
        act.kind    = tonc_pkg::ACT_DATA;
        act.cmd     = 8'd0;
        act.data    = rx_byte;

        case (state_reg)
            tonc_pkg::ST_IAC:
            begin
                state_next = tonc_pkg::ST_NORMAL;
                if (rx_byte inside {tonc_pkg::TN_WILL, tonc_pkg::TN_WONT,
                                    tonc_pkg::TN_DO, tonc_pkg::TN_DONT})
                begin
                    held_next  = rx_byte;
                    state_next = tonc_pkg::ST_CMD;
                end
                else if (rx_byte == tonc_pkg::TN_SB)
                begin
                    subpos_next = 2'd0;
                    state_next  = tonc_pkg::ST_SB;
                end
                else if (rx_byte == tonc_pkg::TN_IAC)
                begin
                    act_valid = 1'b1;
                end
            end
            tonc_pkg::ST_CMD:
            begin
                state_next = tonc_pkg::ST_NORMAL;
                act.kind   = tonc_pkg::ACT_CMD;
                if (held_reg == tonc_pkg::TN_WILL && rx_byte == tonc_pkg::OPT_ECHO)
                begin
                    echo_next = 1'b0;
                    act.cmd   = tonc_pkg::TN_DO;
                    act_valid = 1'b1;
                end
                else if (held_reg == tonc_pkg::TN_WONT && rx_byte == tonc_pkg::OPT_ECHO)
                begin
                    echo_next = 1'b1;
                    act.cmd   = tonc_pkg::TN_DONT;
                    act_valid = 1'b1;
                end
                else if (held_reg == tonc_pkg::TN_WILL)
                begin
                    act.cmd   = tonc_pkg::TN_DONT;
                    act_valid = 1'b1;
                end
                else if (held_reg == tonc_pkg::TN_DO)
                begin
                    if (rx_byte == tonc_pkg::OPT_NAWS)
                    begin
                        act.kind  = tonc_pkg::ACT_NAWS;
                        act_valid = 1'b1;
                    end
                    else if (rx_byte != tonc_pkg::OPT_TTYPE)
                    begin
                        act.cmd   = tonc_pkg::TN_WONT;
                        act_valid = 1'b1;
                    end
                end
            end
            tonc_pkg::ST_SB:
            begin
                if (rx_byte == tonc_pkg::TN_IAC)
                begin
                    state_next = tonc_pkg::ST_SB_IAC;
                end
                else if (subpos_reg == 2'd0)
                begin
                    subopt_next = rx_byte;
                    subpos_next = 2'd1;
                end
                else if (subpos_reg == 2'd1)
                begin
                    held_next   = rx_byte;
                    subpos_next = 2'd2;
                end
            end
            tonc_pkg::ST_SB_IAC:
            begin
                if (rx_byte == tonc_pkg::TN_SE)
                begin
                    state_next = tonc_pkg::ST_NORMAL;
                    if (subopt_reg == tonc_pkg::OPT_TTYPE && held_reg == tonc_pkg::SUB_SEND)
                    begin
                        act.kind  = tonc_pkg::ACT_TTYPE;
                        act_valid = 1'b1;
                    end
                end
                else if (rx_byte != tonc_pkg::TN_IAC)
                begin
                    state_next = tonc_pkg::ST_SB;
                end
            end
            default:
            begin
                if (rx_byte == tonc_pkg::TN_IAC)
                begin
                    state_next = tonc_pkg::ST_IAC;
                end
                else
                begin
                    state_next = tonc_pkg::ST_NORMAL;
                    act_valid  = 1'b1;
                end
            end
        endcase

        act.echo  = echo_next;
        act_valid = act_valid & accept;
    end

endmodule

`default_nettype wire

>>> src/tonc_fifo.sv
// Short action queue between the parser and the reply emitter.
`default_nettype none

module tonc_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  tonc_pkg::action_t     push_data,
    input  wire logic             pop,
    output tonc_pkg::action_t     head,
    output logic                  not_empty,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tonc_pkg::action_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/tonc_emitter.sv
// Back end: expands queued actions into output bytes through an output register.
`default_nettype none

module tonc_emitter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  tonc_pkg::action_t     head,
    input  wire logic             head_valid,
    output logic                  pop,
    input  wire logic [15:0]      columns,
    input  wire logic [15:0]      rows,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  destination,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output logic                  echo_local
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       dest_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       echo_reg;

    logic       load;
    logic       is_last;
    logic [7:0] cur_byte;
    logic [3:0] last_idx;

    always_comb
    begin
        case (head.kind)
            tonc_pkg::ACT_DATA:  last_idx = 4'd0;
            tonc_pkg::ACT_CMD:   last_idx = 4'd2;
            tonc_pkg::ACT_NAWS:  last_idx = 4'd11;
            tonc_pkg::ACT_TTYPE: last_idx = 4'd10;
            default:             last_idx = 4'd0;
        endcase
    end

    always_comb
    begin
        cur_byte = tonc_pkg::TN_IAC;
        case (head.kind)
            tonc_pkg::ACT_DATA:
                cur_byte = head.data;
            tonc_pkg::ACT_CMD:
                case (idx_reg)
                    4'd0:    cur_byte = tonc_pkg::TN_IAC;
                    4'd1:    cur_byte = head.cmd;
                    default: cur_byte = head.data;
                endcase
            tonc_pkg::ACT_NAWS:
                case (idx_reg)
                    4'd0:    cur_byte = tonc_pkg::TN_IAC;
                    4'd1:    cur_byte = tonc_pkg::TN_WILL;
                    4'd2:    cur_byte = tonc_pkg::OPT_NAWS;
                    4'd3:    cur_byte = tonc_pkg::TN_IAC;
                    4'd4:    cur_byte = tonc_pkg::TN_SB;
                    4'd5:    cur_byte = tonc_pkg::OPT_NAWS;
                    4'd6:    cur_byte = columns[15:8];
                    4'd7:    cur_byte = columns[7:0];
                    4'd8:    cur_byte = rows[15:8];
                    4'd9:    cur_byte = rows[7:0];
                    4'd10:   cur_byte = tonc_pkg::TN_IAC;
                    default: cur_byte = tonc_pkg::TN_SE;
                endcase
            tonc_pkg::ACT_TTYPE:
                case (idx_reg)
                    4'd0:    cur_byte = tonc_pkg::TN_IAC;
                    4'd1:    cur_byte = tonc_pkg::TN_SB;
                    4'd2:    cur_byte = tonc_pkg::OPT_TTYPE;
                    4'd3:    cur_byte = tonc_pkg::SUB_IS;
                    4'd4:    cur_byte = 8'h76;
                    4'd5:    cur_byte = 8'h74;
                    4'd6:    cur_byte = 8'h31;
                    4'd7:    cur_byte = 8'h30;
                    4'd8:    cur_byte = 8'h30;
                    4'd9:    cur_byte = tonc_pkg::TN_IAC;
                    default: cur_byte = tonc_pkg::TN_SE;
                endcase
            default:
                cur_byte = head.data;
        endcase
    end

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == last_idx);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dest_reg <= (head.kind == tonc_pkg::ACT_DATA) ? tonc_pkg::DEST_DISPLAY
                                                          : tonc_pkg::DEST_NETWORK;
            byte_reg <= cur_byte;
            last_reg <= is_last;
            echo_reg <= head.echo;
        end
    end

    assign out_valid   = valid_reg;
    assign destination = dest_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign echo_local  = echo_reg;

endmodule

`default_nettype wire

>>> src/telnet_option_negotiator_core.sv
// Top level of the telnet option negotiator: parser, action queue, emitter, APB registers.
//
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received telnet byte per item.
//   Output channel (out_valid/out_ready) delivers result items: destination (0 display,
//   1 network), out_byte, last_of_run on the final item caused by one input, and
//   echo_local, the echo flag after that input.
//   A byte that causes results is queued as an action, which the output register then loads.
//   Plain data flows at one item per cycle while out_ready stays high. Option replies
//   are 3 bytes long, the window-size reply 12 and the terminal-type reply 11; the emitter
//   produces one byte per cycle while out_ready is high, and that sets the drain rate.
//   The parser accepts a byte every cycle while the action queue (QUEUE_DEPTH entries)
//   has room; it keeps accepting while a long reply drains or the receiver stalls,
//   until the queue fills, then drops in_ready.
//   A stall on out_ready holds the output register; nothing is lost or repeated.
//   Reset: parser returns to the data state, echo on, queue empty, window size 80x25.
//   APB: register 0 (byte address 0) window_columns, register 1 (address 4)
//   window_rows, 16 bits each; write them only while the block is idle.
`default_nettype none

module telnet_option_negotiator_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Receive byte channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             destination,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             echo_local,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] columns_reg;
    logic [15:0] rows_reg;
    logic        cfg_write;

    tonc_pkg::action_t act, head;
    logic              act_valid;
    logic              head_valid;
    logic              pop;
    logic              queue_full;
    logic              accept;

    // Configuration registers: decode on address bit 2 only, one word per register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= tonc_pkg::COLS_RESET;
            rows_reg    <= tonc_pkg::ROWS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tonc_pkg::REG_COLUMNS)
            begin
                columns_reg <= pwdata[15:0];
            end
            else
            begin
                rows_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == tonc_pkg::REG_ROWS)
        begin
            prdata = {16'd0, rows_reg};
        end
        else
        begin
            prdata = {16'd0, columns_reg};
        end
    end

    // Take a byte whenever the queue has room for the action it might produce
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    tonc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .act       (act),
        .act_valid (act_valid)
    );

    tonc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (act_valid),
        .push_data (act),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    tonc_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .columns     (columns_reg),
        .rows        (rows_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .destination (destination),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .echo_local  (echo_local)
    );

endmodule

`default_nettype wire

>>> src/tonc_checker.sv
// Port-level checker of the telnet option negotiator and its bind.
`default_nettype none

`include "telnet_option_negotiator_core_assert.svh"

module tonc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       destination,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run,
    input wire logic       pready
);

    `TONC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `TONC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_byte) && $stable(destination))
    `TONC_ASSERT_NOW(a_display_single, clk, rst_n, out_valid && !destination, last_of_run)
    `TONC_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind telnet_option_negotiator_core tonc_checker u_tonc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .destination (destination),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .pready      (pready)
);

`default_nettype wire

>>> dv/tb_telnet_option_negotiator_core.sv
// Self-checking testbench for the telnet option negotiator core.
`timescale 1ns / 1ps

module tb_telnet_option_negotiator_core;

    // Cycles to wait after the last expected item before touching the registers or
    // ending the run, with margin.
    localparam int DRAIN_CYCLES = 16;

    // Terminal name sent in the terminal-type reply, first character in the top byte.
    localparam logic [39:0] TERM_NAME = "vt100";

    // One result item as it leaves the block
    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       last;
        logic       echo;
    } tn_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        destination;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        echo_local;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the negotiator: parser state, held bytes, echo and window size
    tonc_pkg::parse_state_t parser_st;
    logic [7:0]   held_cmd;
    logic [7:0]   sub_opt;
    logic [1:0]   sub_count;
    logic         echo_on;
    logic [15:0]  win_cols;
    logic [15:0]  win_rows;

    // Replies built for the current byte ({destination, byte}) and the items still owed
    logic [8:0]   reply_q[$];
    tn_result_t   expected_q[$];

    int mismatch_count = 0;
    int rx_sent        = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;

    telnet_option_negotiator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .destination (destination),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .echo_local  (echo_local),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 clk = ~clk;

    // Receiver: drop out_ready at random on the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hard stop in case the block hangs or loses items
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void add_reply(input logic dest, input logic [7:0] b);
        reply_q.push_back({dest, b});
    endfunction

    function automatic void add_cmd(input logic [7:0] cmd, input logic [7:0] opt);
        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_IAC);
        add_reply(tonc_pkg::DEST_NETWORK, cmd);
        add_reply(tonc_pkg::DEST_NETWORK, opt);
    endfunction

    // Advance the shadow parser by one received byte and queue the items it causes.
    // The echo field carries the flag as it stands after the byte is handled.
    function automatic void predict_negotiation(input logic [7:0] c);
        tn_result_t r;
        reply_q.delete();
        case (parser_st)
            tonc_pkg::ST_IAC:
            begin
                if (c == tonc_pkg::TN_WILL || c == tonc_pkg::TN_WONT ||
                    c == tonc_pkg::TN_DO || c == tonc_pkg::TN_DONT)
                begin
                    held_cmd  = c;
                    parser_st = tonc_pkg::ST_CMD;
                end
                else if (c == tonc_pkg::TN_SB)
                begin
                    sub_count = 2'd0;
                    parser_st = tonc_pkg::ST_SB;
                end
                else
                begin
                    // Doubled IAC is a literal 0xFF; any other command is dropped
                    if (c == tonc_pkg::TN_IAC)
                        add_reply(tonc_pkg::DEST_DISPLAY, tonc_pkg::TN_IAC);
                    parser_st = tonc_pkg::ST_NORMAL;
                end
            end
            tonc_pkg::ST_CMD:
            begin
                if (held_cmd == tonc_pkg::TN_WILL && c == tonc_pkg::OPT_ECHO)
                begin
                    echo_on = 1'b0;
                    add_cmd(tonc_pkg::TN_DO, c);
                end
                else if (held_cmd == tonc_pkg::TN_WONT && c == tonc_pkg::OPT_ECHO)
                begin
                    echo_on = 1'b1;
                    add_cmd(tonc_pkg::TN_DONT, c);
                end
                else if (held_cmd == tonc_pkg::TN_WILL)
                    add_cmd(tonc_pkg::TN_DONT, c);
                else if (held_cmd == tonc_pkg::TN_DO)
                begin
                    if (c == tonc_pkg::OPT_NAWS)
                    begin
                        // Window size goes out raw: a 0xFF byte is not doubled
                        add_cmd(tonc_pkg::TN_WILL, c);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_IAC);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_SB);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::OPT_NAWS);
                        add_reply(tonc_pkg::DEST_NETWORK, win_cols[15:8]);
                        add_reply(tonc_pkg::DEST_NETWORK, win_cols[7:0]);
                        add_reply(tonc_pkg::DEST_NETWORK, win_rows[15:8]);
                        add_reply(tonc_pkg::DEST_NETWORK, win_rows[7:0]);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_IAC);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_SE);
                    end
                    else if (c != tonc_pkg::OPT_TTYPE)
                        add_cmd(tonc_pkg::TN_WONT, c);
                end
                parser_st = tonc_pkg::ST_NORMAL;
            end
            tonc_pkg::ST_SB:
            begin
                if (c == tonc_pkg::TN_IAC)
                    parser_st = tonc_pkg::ST_SB_IAC;
                else if (sub_count == 2'd0)
                begin
                    sub_opt   = c;
                    sub_count = 2'd1;
                end
                else if (sub_count == 2'd1)
                begin
                    held_cmd  = c;
                    sub_count = 2'd2;
                end
            end
            tonc_pkg::ST_SB_IAC:
            begin
                if (c == tonc_pkg::TN_SE)
                begin
                    if (sub_opt == tonc_pkg::OPT_TTYPE && held_cmd == tonc_pkg::SUB_SEND)
                    begin
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_IAC);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_SB);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::OPT_TTYPE);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::SUB_IS);
                        for (int i = 4; i >= 0; i--)
                            add_reply(tonc_pkg::DEST_NETWORK, TERM_NAME[i*8 +: 8]);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_IAC);
                        add_reply(tonc_pkg::DEST_NETWORK, tonc_pkg::TN_SE);
                    end
                    parser_st = tonc_pkg::ST_NORMAL;
                end
                else if (c != tonc_pkg::TN_IAC)
                    parser_st = tonc_pkg::ST_SB;
            end
            default:
            begin
                if (c == tonc_pkg::TN_IAC)
                    parser_st = tonc_pkg::ST_IAC;
                else
                begin
                    add_reply(tonc_pkg::DEST_DISPLAY, c);
                    parser_st = tonc_pkg::ST_NORMAL;
                end
            end
        endcase
        for (int i = 0; i < reply_q.size(); i++)
        begin
            r.dest = reply_q[i][8];
            r.data = reply_q[i][7:0];
            r.last = (i == reply_q.size() - 1);
            r.echo = echo_on;
            expected_q.push_back(r);
        end
    endfunction

    // Compare every accepted result item with the oldest one owed
    always @(posedge clk)
    begin
        tn_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected item: destination %0d out_byte 0x%02h",
                       destination, out_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("destination", 32'(want.dest), 32'(destination));
                check_field("out_byte", 32'(want.data), 32'(out_byte));
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                check_field("echo_local", 32'(want.echo), 32'(echo_local));
            end
        end
    end

    // Offer one received byte, idling the sender now and then, and hold
    // it until the block takes it. Prediction happens at the accepting edge.
    task automatic send_rx(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_negotiation(b);
        rx_sent++;
    endtask

    // Drop valid and let every owed item, and any byte still in flight, drain out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one window register over APB (setup, access), then read it back.
    // Upper data bits carry noise; the register keeps only 16 bits.
    task automatic write_window(input logic reg_idx, input logic [15:0] value);
        logic [31:0] word;
        word = {16'($urandom), value};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (reg_idx == tonc_pkg::REG_COLUMNS)
            win_cols = value;
        else
            win_rows = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", {16'h0000, value}, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_seq(input logic [7:0] s[$]);
        foreach (s[i])
            send_rx(s[i]);
    endtask

    // Plain bytes at both ends of the range and a doubled IAC
    task automatic test_plain_data();
        send_seq('{8'h00, 8'h80, 8'hFE, tonc_pkg::TN_IAC, tonc_pkg::TN_IAC, 8'h7F});
    endtask

    // Single-byte commands that are swallowed without output
    task automatic test_single_commands();
        send_seq('{tonc_pkg::TN_IAC, 8'hF1, tonc_pkg::TN_IAC, tonc_pkg::TN_SE});
    endtask

    // Every reply rule of the option commands, NAWS with the reset window size
    task automatic test_option_replies();
        send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_WILL, tonc_pkg::OPT_ECHO,
                   tonc_pkg::TN_IAC, tonc_pkg::TN_WONT, tonc_pkg::OPT_ECHO});
        send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_WILL, 8'h00,
                   tonc_pkg::TN_IAC, tonc_pkg::TN_WONT, 8'hFF});
        send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_DO, tonc_pkg::OPT_NAWS,
                   tonc_pkg::TN_IAC, tonc_pkg::TN_DO, tonc_pkg::OPT_TTYPE});
        send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_DO, 8'hFF,
                   tonc_pkg::TN_IAC, tonc_pkg::TN_DONT, tonc_pkg::OPT_ECHO});
    endtask

    // Terminal-type request with a doubled IAC and extra bytes, then an unknown one
    task automatic test_subnegotiation();
        send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_SB, tonc_pkg::OPT_TTYPE,
                   tonc_pkg::SUB_SEND, 8'h55, tonc_pkg::TN_IAC, tonc_pkg::TN_IAC,
                   tonc_pkg::TN_SE});
        send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_SB, tonc_pkg::OPT_NAWS,
                   tonc_pkg::SUB_SEND, tonc_pkg::TN_IAC, 8'h07, tonc_pkg::TN_IAC,
                   tonc_pkg::TN_SE});
    endtask

    // Window size at its extremes, each reported by a DO NAWS
    task automatic test_window_size();
        logic [15:0] cols_set[3] = '{16'hFFFF, 16'h0000, 16'hFF00};
        logic [15:0] rows_set[3] = '{16'h0000, 16'hFFFF, 16'h00FF};
        for (int i = 0; i < 3; i++)
        begin
            wait_idle();
            write_window(tonc_pkg::REG_COLUMNS, cols_set[i]);
            write_window(tonc_pkg::REG_ROWS, rows_set[i]);
            send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_DO, tonc_pkg::OPT_NAWS});
        end
    endtask

    function automatic logic [7:0] pick_option();
        case ($urandom_range(0, 4))
            0, 1:    return tonc_pkg::OPT_ECHO;
            2:       return tonc_pkg::OPT_NAWS;
            3:       return tonc_pkg::OPT_TTYPE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed telnet sequences with random content, some noise
    task automatic send_random_sequence();
        int kind;
        int extra;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            send_rx(8'($urandom_range(0, 254)));
        else if (kind < 38)
            send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_IAC});
        else if (kind < 68)
        begin
            case ($urandom_range(0, 3))
                0:       send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_WILL, pick_option()});
                1:       send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_WONT, pick_option()});
                2:       send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_DO, pick_option()});
                default: send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_DONT, pick_option()});
            endcase
        end
        else if (kind < 84)
        begin
            // Header bytes are optional; random body bytes may hold IAC pairs
            send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_SB});
            if ($urandom_range(0, 9) != 0)
                send_rx(($urandom_range(0, 9) < 6) ? tonc_pkg::OPT_TTYPE : 8'($urandom));
            if ($urandom_range(0, 9) != 0)
                send_rx(($urandom_range(0, 9) < 7) ? tonc_pkg::SUB_SEND : 8'($urandom));
            extra = $urandom_range(0, 3);
            repeat (extra)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_IAC});
                else
                    send_rx(8'($urandom));
            end
            send_seq('{tonc_pkg::TN_IAC, tonc_pkg::TN_SE});
        end
        else if (kind < 92)
            send_seq('{tonc_pkg::TN_IAC, 8'($urandom)});
        else
            send_rx(8'($urandom));
    endtask

    // One random phase with its own window size and idling pattern
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int start;
        wait_idle();
        write_window(tonc_pkg::REG_COLUMNS, 16'($urandom));
        write_window(tonc_pkg::REG_ROWS, 16'($urandom));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = rx_sent;
        while (rx_sent - start < count)
            send_random_sequence();
    endtask

    initial
    begin
        // Drive every input but out_ready to a known value before reset
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;

        parser_st = tonc_pkg::ST_NORMAL;
        held_cmd  = 8'h00;
        sub_opt   = 8'h00;
        sub_count = 2'd0;
        echo_on   = 1'b1;
        win_cols  = tonc_pkg::COLS_RESET;
        win_rows  = tonc_pkg::ROWS_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed checks run with the sender lightly idle and the receiver busy
        tx_idle_pct = 14;
        rx_idle_pct = 55;
        test_plain_data();
        test_single_commands();
        test_option_replies();
        test_subnegotiation();
        test_window_size();

        test_random_traffic(14, 55, 50);
        test_random_traffic(55, 14, 50);
        test_random_traffic(0, 0, 50);

        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
